// ===== sv/fdep_pkg.sv =====
package fdep_pkg;

  // Name storage geometry
  localparam int NAME_SLOTS = 32;
  localparam int SLOT_CHARS = 13;
  localparam int SLOT_W     = 8 * SLOT_CHARS;
  localparam int SLOT_IW    = (NAME_SLOTS > 1) ? $clog2(NAME_SLOTS) : 1;
  localparam int CNT_W      = 4;

  // Command queue between front and back; depth must be a power of two
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Directory entry codes
  localparam logic [7:0] B0_END      = 8'h00;
  localparam logic [7:0] B0_DELETED  = 8'hE5;
  localparam logic [7:0] ATTR_LFN    = 8'h0F;
  localparam logic [7:0] ATTR_DIR    = 8'h10;
  localparam logic [7:0] ATTR_ARCH   = 8'h20;
  localparam logic [7:0] LFN_ID_MASK = 8'h1F;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_DOT      = 8'h2E;
  localparam logic [7:0] CH_NUL      = 8'h00;
  localparam logic [31:0] CLUSTER_DEFAULT = 32'd2;

  // Byte offsets of the 13 character low bytes inside a long-name entry
  typedef logic [4:0] lfn_off_t;
  localparam lfn_off_t LFN_OFFSETS [SLOT_CHARS] = '{
    5'd1, 5'd3, 5'd5, 5'd7, 5'd9, 5'd14, 5'd16, 5'd18, 5'd20, 5'd22, 5'd24, 5'd28, 5'd30
  };

  typedef enum logic [1:0] {
    CMD_END,
    CMD_LFN,
    CMD_FILE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t            kind;
    logic [SLOT_IW-1:0]   slot;
    logic [SLOT_W-1:0]    chars;
    logic [CNT_W-1:0]     count;
    logic                 is_file;
    logic [31:0]          size;
    logic [31:0]          cluster;
  } cmd_t;

  typedef struct packed {
    logic              record_kind;
    logic [63:0]       chars_lo;
    logic [39:0]       chars_hi;
    logic [CNT_W-1:0]  char_count;
    logic              is_file;
    logic [31:0]       size_bytes;
    logic [31:0]       start_cluster;
    logic              last_piece;
  } result_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_EMIT
  } back_state_t;

endpackage

// ===== sv/fdep_ram.sv =====
module fdep_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/fdep_front.sv =====
module fdep_front import fdep_pkg::*; (
  input  logic [63:0] entry_bytes_0_7,
  input  logic [63:0] entry_bytes_8_15,
  input  logic [63:0] entry_bytes_16_23,
  input  logic [63:0] entry_bytes_24_31,
  output logic        push,
  output cmd_t        cmd
);

  logic [255:0]      raw;
  logic [7:0]        b0;
  logic [7:0]        attr;
  logic [4:0]        lfn_id;
  logic [7:0]        ex [4];
  logic [3:0]        nl;
  logic [1:0]        el;
  logic [SLOT_W-1:0] lfn_chars;
  logic [SLOT_W-1:0] short_chars;
  logic [CNT_W-1:0]  short_count;
  logic [31:0]       clus;

  assign raw    = {entry_bytes_24_31, entry_bytes_16_23, entry_bytes_8_15, entry_bytes_0_7};
  assign b0     = raw[7:0];
  assign attr   = raw[95:88];
  assign lfn_id = 5'(b0 & LFN_ID_MASK);
  assign ex[0]  = raw[71:64];
  assign ex[1]  = raw[79:72];
  assign ex[2]  = raw[87:80];
  assign ex[3]  = CH_NUL;

  // Gather the character low bytes of a long-name entry
  always_comb begin
    for (int i = 0; i < SLOT_CHARS; i++) begin
      lfn_chars[8*i +: 8] = raw[8*int'(LFN_OFFSETS[i]) +: 8];
    end
  end

  // Trim the 8.3 name and extension: drop trailing spaces, cut at first NUL
  always_comb begin
    logic [3:0] nm_len;
    logic [3:0] nm_nul;
    logic [1:0] ex_len;
    logic [1:0] ex_nul;
    nm_len = 4'd0;
    nm_nul = 4'd8;
    for (int i = 0; i < 8; i++) begin
      if (raw[8*i +: 8] != CH_SPACE) nm_len = 4'(i + 1);
    end
    for (int i = 7; i >= 0; i--) begin
      if (raw[8*i +: 8] == CH_NUL) nm_nul = 4'(i);
    end
    ex_len = 2'd0;
    ex_nul = 2'd3;
    for (int i = 0; i < 3; i++) begin
      if (ex[i] != CH_SPACE) ex_len = 2'(i + 1);
    end
    for (int i = 2; i >= 0; i--) begin
      if (ex[i] == CH_NUL) ex_nul = 2'(i);
    end
    nl = (nm_nul < nm_len) ? nm_nul : nm_len;
    el = (ex_nul < ex_len) ? ex_nul : ex_len;
  end

  // Assemble the short-name piece with a dot only when an extension remains
  always_comb begin
    logic [3:0] off;
    off = 4'd0;
    for (int p = 0; p < SLOT_CHARS; p++) begin
      off = 4'(p) - nl - 4'd1;
      if (4'(p) < nl) begin
        short_chars[8*p +: 8] = raw[8*p +: 8];
      end else if (el != 2'd0 && 4'(p) == nl) begin
        short_chars[8*p +: 8] = CH_DOT;
      end else if (el != 2'd0 && 4'(p) > nl && off < {2'b00, el}) begin
        short_chars[8*p +: 8] = ex[off[1:0]];
      end else begin
        short_chars[8*p +: 8] = CH_NUL;
      end
    end
    short_count = nl + ((el != 2'd0) ? ({2'b00, el} + 4'd1) : 4'd0);
  end

  // Start cluster from high and low words, zero maps to the root default
  always_comb begin
    clus = {raw[175:160], raw[223:208]};
    if (clus == 32'd0) clus = CLUSTER_DEFAULT;
  end

  // Classify the entry
  always_comb begin
    push        = 1'b0;
    cmd         = '0;
    cmd.kind    = CMD_FILE;
    cmd.slot    = lfn_id[SLOT_IW-1:0];
    cmd.chars   = (attr == ATTR_LFN) ? lfn_chars : short_chars;
    cmd.count   = short_count;
    cmd.is_file = ((attr & ATTR_ARCH) != 8'd0);
    cmd.size    = raw[255:224];
    cmd.cluster = clus;
    if (b0 == B0_END) begin
      push     = 1'b1;
      cmd.kind = CMD_END;
    end else if (b0 == B0_DELETED) begin
      push = 1'b0;
    end else if (attr == ATTR_LFN) begin
      cmd.kind = CMD_LFN;
      push     = (int'(lfn_id) < NAME_SLOTS);
    end else if ((attr & (ATTR_DIR | ATTR_ARCH)) != 8'd0) begin
      push = 1'b1;
    end
  end

endmodule

// ===== sv/fdep_queue.sv =====
module fdep_queue import fdep_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output logic empty,
  output cmd_t head
);

  cmd_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wp_r, wp_nxt;
  logic [QPTR_W-1:0] rp_r, rp_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == QCNT_W'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rp_r];

  // Advance pointers and fill count
  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Store the item
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

endmodule

// ===== sv/fdep_back.sv =====
module fdep_back import fdep_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    q_empty,
  input  cmd_t    q_head,
  output logic    q_pop,
  input  logic    out_ready,
  output logic    out_valid,
  output result_t out_res
);

  back_state_t         state_r, state_nxt;
  logic [NAME_SLOTS-1:0] valid_r, valid_nxt;
  logic [NAME_SLOTS-1:0] pend_r, pend_nxt;
  logic                out_valid_r, out_valid_nxt;
  result_t             res_r, res_nxt;
  logic                out_free;
  logic [SLOT_IW-1:0]  first_idx;
  logic                ram_we;
  logic                ram_re;
  logic [SLOT_W-1:0]   ram_rdata;
  logic [CNT_W-1:0]    rcnt;
  logic [SLOT_W-1:0]   rchars;

  fdep_ram #(
    .WIDTH(SLOT_W),
    .DEPTH(NAME_SLOTS)
  ) u_slots (
    .clk  (clk),
    .we   (ram_we),
    .waddr(q_head.slot),
    .wdata(q_head.chars),
    .re   (ram_re),
    .raddr(first_idx),
    .rdata(ram_rdata)
  );

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  // Lowest pending slot
  always_comb begin
    first_idx = '0;
    for (int i = NAME_SLOTS - 1; i >= 0; i--) begin
      if (pend_r[i]) first_idx = SLOT_IW'(i);
    end
  end

  // Cut the stored slot at its first NUL and zero the rest
  always_comb begin
    rcnt = CNT_W'(SLOT_CHARS);
    for (int i = SLOT_CHARS - 1; i >= 0; i--) begin
      if (ram_rdata[8*i +: 8] == CH_NUL) rcnt = CNT_W'(i);
    end
    for (int i = 0; i < SLOT_CHARS; i++) begin
      rchars[8*i +: 8] = (CNT_W'(i) < rcnt) ? ram_rdata[8*i +: 8] : CH_NUL;
    end
  end

  // Sequencer: execute commands and emit pieces
  always_comb begin
    state_nxt     = state_r;
    valid_nxt     = valid_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r && !out_ready;
    res_nxt       = res_r;
    q_pop         = 1'b0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          unique case (q_head.kind)
            CMD_END: begin
              if (out_free) begin
                res_nxt             = '0;
                res_nxt.record_kind = 1'b1;
                res_nxt.last_piece  = 1'b1;
                out_valid_nxt       = 1'b1;
                valid_nxt           = '0;
                q_pop               = 1'b1;
              end
            end
            CMD_LFN: begin
              ram_we                = 1'b1;
              valid_nxt[q_head.slot] = 1'b1;
              q_pop                 = 1'b1;
            end
            CMD_FILE: begin
              if (valid_r == '0) begin
                if (out_free) begin
                  res_nxt.record_kind   = 1'b0;
                  res_nxt.chars_lo      = q_head.chars[63:0];
                  res_nxt.chars_hi      = q_head.chars[SLOT_W-1:64];
                  res_nxt.char_count    = q_head.count;
                  res_nxt.is_file       = q_head.is_file;
                  res_nxt.size_bytes    = q_head.size;
                  res_nxt.start_cluster = q_head.cluster;
                  res_nxt.last_piece    = 1'b1;
                  out_valid_nxt         = 1'b1;
                  q_pop                 = 1'b1;
                end
              end else begin
                pend_nxt  = valid_r;
                state_nxt = BK_READ;
              end
            end
            default: begin
              q_pop = 1'b1;
            end
          endcase
        end
      end
      BK_READ: begin
        ram_re              = 1'b1;
        pend_nxt[first_idx] = 1'b0;
        state_nxt           = BK_EMIT;
      end
      BK_EMIT: begin
        if (out_free) begin
          res_nxt.record_kind   = 1'b0;
          res_nxt.chars_lo      = rchars[63:0];
          res_nxt.chars_hi      = rchars[SLOT_W-1:64];
          res_nxt.char_count    = rcnt;
          res_nxt.is_file       = 1'b0;
          res_nxt.size_bytes    = '0;
          res_nxt.start_cluster = '0;
          res_nxt.last_piece    = 1'b0;
          out_valid_nxt         = 1'b1;
          if (pend_r == '0) begin
            res_nxt.is_file       = q_head.is_file;
            res_nxt.size_bytes    = q_head.size;
            res_nxt.start_cluster = q_head.cluster;
            res_nxt.last_piece    = 1'b1;
            valid_nxt             = '0;
            q_pop                 = 1'b1;
            state_nxt             = BK_IDLE;
          end else begin
            state_nxt = BK_READ;
          end
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      valid_r     <= '0;
      pend_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold result payload
  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

endmodule

// ===== sv/fat_directory_entry_parser_unit.sv =====
// A result item passes through the command queue and then the output register; a stored
// long-name piece passes the queue, the IDLE, READ and EMIT states and the output register.
// Throughput: one entry per cycle for end, deleted, long-name and short-name entries while
// the queue is not full; a file entry with stored name slots takes one READ and one EMIT
// state per slot (one slot RAM read per piece). A 2-deep command queue decouples input
// acceptance from result emission. Reset (rst_n low, synchronous) empties the queue, clears
// all slot valid bits and drops any pending result; slot RAM contents are not cleared.
module fat_directory_entry_parser_unit import fdep_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_entry_bytes_0_7,
  input  logic [63:0] in_entry_bytes_8_15,
  input  logic [63:0] in_entry_bytes_16_23,
  input  logic [63:0] in_entry_bytes_24_31,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_record_kind,
  output logic [63:0] out_chars_0_7,
  output logic [39:0] out_chars_8_12,
  output logic [3:0]  out_char_count,
  output logic        out_is_file,
  output logic [31:0] out_size_bytes,
  output logic [31:0] out_start_cluster,
  output logic        out_last_piece
);

  logic    front_push;
  cmd_t    front_cmd;
  logic    q_push;
  logic    q_full;
  logic    q_empty;
  logic    q_pop;
  cmd_t    q_head;
  result_t res;

  fdep_front u_front (
    .entry_bytes_0_7  (in_entry_bytes_0_7),
    .entry_bytes_8_15 (in_entry_bytes_8_15),
    .entry_bytes_16_23(in_entry_bytes_16_23),
    .entry_bytes_24_31(in_entry_bytes_24_31),
    .push             (front_push),
    .cmd              (front_cmd)
  );

  // Accept whenever the queue has room; skipped entries are dropped here
  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready && front_push;

  fdep_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(front_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  fdep_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .out_ready(out_ready),
    .out_valid(out_valid),
    .out_res  (res)
  );

  assign out_record_kind   = res.record_kind;
  assign out_chars_0_7     = res.chars_lo;
  assign out_chars_8_12    = res.chars_hi;
  assign out_char_count    = res.char_count;
  assign out_is_file       = res.is_file;
  assign out_size_bytes    = res.size_bytes;
  assign out_start_cluster = res.start_cluster;
  assign out_last_piece    = res.last_piece;

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("command popped from empty queue");

  a_end_record: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_record_kind |-> out_last_piece && out_char_count == 4'd0)
    else $error("end record malformed");

  a_piece_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_piece |->
      !out_is_file && out_size_bytes == 32'd0 && out_start_cluster == 32'd0)
    else $error("non-final piece carries entry fields");

  a_cluster_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_piece && !out_record_kind |-> out_start_cluster != 32'd0)
    else $error("final piece has zero start cluster");

endmodule

// ===== test/tb.sv =====
module tb;

  localparam int SLOT_COUNT     = fdep_pkg::NAME_SLOTS;
  localparam int NAME_LEN       = 13;
  localparam int NO_NUL         = NAME_LEN;
  localparam int ATTR_BYTE      = 11;
  localparam int LIMIT_CYCLES   = 1000000;
  localparam int SETTLE_CYCLES  = 20;
  localparam int RANDOM_ENTRIES = 390;
  localparam int CALM_TAIL      = 60;
  localparam int MAX_PRINTED    = 100;

  localparam logic [7:0] FIRST_END      = 8'h00;
  localparam logic [7:0] FIRST_DELETED  = 8'hE5;
  localparam logic [7:0] ATTR_LONG      = 8'h0F;
  localparam logic [7:0] ATTR_VOLUME_ID = 8'h08;
  localparam logic [7:0] ATTR_DIR       = 8'h10;
  localparam logic [7:0] ATTR_ARCHIVE   = 8'h20;
  localparam logic [7:0] ID_BITS        = 8'h1F;
  localparam logic [7:0] SPACE          = 8'h20;
  localparam logic [7:0] DOT            = 8'h2E;
  localparam logic [7:0] NUL            = 8'h00;
  localparam logic [7:0] FILL_LETTER    = 8'h41;
  localparam logic       KIND_PIECE     = 1'b0;
  localparam logic       KIND_END       = 1'b1;

  // Byte positions of the low character bytes in a long-name entry
  localparam int CHAR_POS [NAME_LEN] = '{1, 3, 5, 7, 9, 14, 16, 18, 20, 22, 24, 28, 30};

  typedef struct packed {
    logic        record_kind;
    logic [63:0] chars_lo;
    logic [39:0] chars_hi;
    logic [3:0]  char_count;
    logic        is_file;
    logic [31:0] size_bytes;
    logic [31:0] start_cluster;
    logic        last_piece;
  } piece_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [63:0] in_entry_bytes_0_7 = '0;
  logic [63:0] in_entry_bytes_8_15 = '0;
  logic [63:0] in_entry_bytes_16_23 = '0;
  logic [63:0] in_entry_bytes_24_31 = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_record_kind;
  logic [63:0] out_chars_0_7;
  logic [39:0] out_chars_8_12;
  logic [3:0]  out_char_count;
  logic        out_is_file;
  logic [31:0] out_size_bytes;
  logic [31:0] out_start_cluster;
  logic        out_last_piece;

  // Predictor state: long-name text per slot and the set of slots in use
  logic [7:0]            name_store [SLOT_COUNT][NAME_LEN];
  logic [SLOT_COUNT-1:0] name_held = '0;
  piece_t                awaited_pieces [$];

  bit quiet = 1'b0;
  int stall_left = 0;
  int cycle_count = 0;
  int mismatches = 0;
  int entries_accepted = 0;
  int results_seen = 0;
  int end_records = 0;
  int most_pieces = 0;
  int random_count = 0;

  fat_directory_entry_parser_unit dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_entry_bytes_0_7   (in_entry_bytes_0_7),
    .in_entry_bytes_8_15  (in_entry_bytes_8_15),
    .in_entry_bytes_16_23 (in_entry_bytes_16_23),
    .in_entry_bytes_24_31 (in_entry_bytes_24_31),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_record_kind      (out_record_kind),
    .out_chars_0_7        (out_chars_0_7),
    .out_chars_8_12       (out_chars_8_12),
    .out_char_count       (out_char_count),
    .out_is_file          (out_is_file),
    .out_size_bytes       (out_size_bytes),
    .out_start_cluster    (out_start_cluster),
    .out_last_piece       (out_last_piece)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  function automatic logic [7:0] byte_at(logic [255:0] e, int k);
    return e[8*k +: 8];
  endfunction

  // Length of a short-name part after dropping trailing spaces and cutting at NUL
  function automatic int kept_len(logic [255:0] e, int first, int n);
    int len;
    int i;
    len = n;
    while (len > 0 && byte_at(e, first + len - 1) == SPACE) len--;
    for (i = 0; i < len; i++) begin
      if (byte_at(e, first + i) == NUL) return i;
    end
    return len;
  endfunction

  function automatic piece_t pack_piece(logic [7:0] text [NAME_LEN], int n);
    piece_t p;
    int i;
    p = '0;
    for (i = 0; i < n; i++) begin
      if (i < 8) p.chars_lo[8*i +: 8] = text[i];
      else p.chars_hi[8*(i-8) +: 8] = text[i];
    end
    p.record_kind = KIND_PIECE;
    p.char_count = 4'(n);
    return p;
  endfunction

  // Work out the name pieces one accepted entry produces and queue them
  task automatic derive_pieces(input logic [255:0] e);
    logic [7:0]  first;
    logic [7:0]  attr;
    logic [7:0]  text [NAME_LEN];
    logic [31:0] cluster;
    piece_t      p;
    piece_t      batch [$];
    int          id, n, nl, el, i, s;
    first = byte_at(e, 0);
    attr = byte_at(e, ATTR_BYTE);
    if (first == FIRST_END) begin
      name_held = '0;
      p = '0;
      p.record_kind = KIND_END;
      p.last_piece = 1'b1;
      awaited_pieces.push_back(p);
      end_records++;
      return;
    end
    if (first == FIRST_DELETED) return;
    if (attr == ATTR_LONG) begin
      id = int'(first & ID_BITS);
      if (id < SLOT_COUNT) begin
        for (i = 0; i < NAME_LEN; i++) name_store[id][i] = byte_at(e, CHAR_POS[i]);
        name_held[id] = 1'b1;
      end
      return;
    end
    if ((attr & (ATTR_DIR | ATTR_ARCHIVE)) == 8'h00) return;

    cluster = {e[175:160], e[223:208]};
    if (cluster == 32'd0) cluster = 32'd2;

    if (name_held == '0) begin
      // Build the 8.3 name, with a dot only when an extension remains
      for (i = 0; i < NAME_LEN; i++) text[i] = NUL;
      nl = kept_len(e, 0, 8);
      el = kept_len(e, 8, 3);
      for (i = 0; i < nl; i++) text[i] = byte_at(e, i);
      n = nl;
      if (el > 0) begin
        text[n] = DOT;
        n++;
        for (i = 0; i < el; i++) text[n + i] = byte_at(e, 8 + i);
        n += el;
      end
      batch.push_back(pack_piece(text, n));
    end else begin
      // Emit stored slots in ascending order, each cut at its first NUL
      for (s = 0; s < SLOT_COUNT; s++) begin
        if (name_held[s]) begin
          for (i = 0; i < NAME_LEN; i++) text[i] = name_store[s][i];
          n = 0;
          while (n < NAME_LEN && text[n] != NUL) n++;
          batch.push_back(pack_piece(text, n));
        end
      end
      name_held = '0;
    end

    p = batch[batch.size() - 1];
    p.is_file = (attr & ATTR_ARCHIVE) != 8'h00;
    p.size_bytes = e[255:224];
    p.start_cluster = cluster;
    p.last_piece = 1'b1;
    batch[batch.size() - 1] = p;
    if (batch.size() > most_pieces) most_pieces = batch.size();
    foreach (batch[j]) awaited_pieces.push_back(batch[j]);
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTED)
      $display("[%0t] result %0d: %s is %h, expected %h", $time, results_seen, what, got, want);
  endtask

  // Compare one accepted result with the oldest expected piece
  task automatic check_piece();
    piece_t got;
    piece_t want;
    got.record_kind = out_record_kind;
    got.chars_lo = out_chars_0_7;
    got.chars_hi = out_chars_8_12;
    got.char_count = out_char_count;
    got.is_file = out_is_file;
    got.size_bytes = out_size_bytes;
    got.start_cluster = out_start_cluster;
    got.last_piece = out_last_piece;
    results_seen++;
    if (awaited_pieces.size() == 0) begin
      report_mismatch("unexpected result", got.chars_lo, '0);
      return;
    end
    want = awaited_pieces.pop_front();
    if (got.record_kind != want.record_kind)
      report_mismatch("record_kind", got.record_kind, want.record_kind);
    if (got.chars_lo != want.chars_lo)
      report_mismatch("chars_0_7", got.chars_lo, want.chars_lo);
    if (got.chars_hi != want.chars_hi)
      report_mismatch("chars_8_12", got.chars_hi, want.chars_hi);
    if (got.char_count != want.char_count)
      report_mismatch("char_count", got.char_count, want.char_count);
    if (got.is_file != want.is_file)
      report_mismatch("is_file", got.is_file, want.is_file);
    if (got.size_bytes != want.size_bytes)
      report_mismatch("size_bytes", got.size_bytes, want.size_bytes);
    if (got.start_cluster != want.start_cluster)
      report_mismatch("start_cluster", got.start_cluster, want.start_cluster);
    if (got.last_piece != want.last_piece)
      report_mismatch("last_piece", got.last_piece, want.last_piece);
  endtask

  // Predict on every accepted entry, then check every accepted result
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        derive_pieces({in_entry_bytes_24_31, in_entry_bytes_16_23,
                       in_entry_bytes_8_15, in_entry_bytes_0_7});
        entries_accepted++;
      end
      if (out_valid && out_ready) check_piece();
    end
  end

  // Stall the result side in random bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 4) == 0) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(0, 6);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Present one entry, maybe after an idle burst, and hold it until accepted
  task automatic send_entry(input logic [255:0] e);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      repeat (gap) begin
        @(negedge clk);
        in_valid = 1'b0;
      end
    end
    @(negedge clk);
    in_valid = 1'b1;
    {in_entry_bytes_24_31, in_entry_bytes_16_23, in_entry_bytes_8_15, in_entry_bytes_0_7} = e;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (awaited_pieces.size() != 0) @(posedge clk);
  endtask

  function automatic logic [255:0] random_bits();
    logic [255:0] e;
    int i;
    for (i = 0; i < 8; i++) e[32*i +: 32] = $urandom();
    return e;
  endfunction

  // Long-name entry for a slot; a NUL goes at nul_at when it lies inside the name
  function automatic logic [255:0] long_name_entry(int id, int nul_at);
    logic [255:0] e;
    logic [7:0]   first;
    logic [7:0]   ch;
    int           i;
    e = random_bits();
    first[4:0] = 5'(id);
    do first[7:5] = 3'($urandom_range(0, 7));
    while (first == FIRST_END || first == FIRST_DELETED);
    e[7:0] = first;
    e[8*ATTR_BYTE +: 8] = ATTR_LONG;
    for (i = 0; i < NAME_LEN; i++) begin
      ch = 8'($urandom_range(1, 255));
      e[8*CHAR_POS[i] +: 8] = (i == nul_at) ? NUL : ch;
    end
    return e;
  endfunction

  function automatic logic [255:0] file_entry(logic [7:0] attr);
    logic [255:0] e;
    e = random_bits();
    if (e[7:0] == FIRST_END || e[7:0] == FIRST_DELETED) e[7:0] = FILL_LETTER;
    e[8*ATTR_BYTE +: 8] = attr;
    // Hit the zero-cluster replacement and a zero high word now and then
    case ($urandom_range(0, 3))
      0: begin
        e[175:160] = '0;
        e[223:208] = '0;
      end
      1: e[175:160] = '0;
      default: ;
    endcase
    return e;
  endfunction

  function automatic logic [255:0] with_tail(logic [255:0] e, logic [15:0] hiw,
                                             logic [15:0] low, logic [31:0] size);
    e[175:160] = hiw;
    e[223:208] = low;
    e[255:224] = size;
    return e;
  endfunction

  function automatic logic [255:0] named_entry(string text, logic [7:0] attr);
    logic [255:0] e;
    int i;
    e = file_entry(attr);
    for (i = 0; i < 11; i++) e[8*i +: 8] = text[i];
    return e;
  endfunction

  // Printable 8.3 name padded with spaces, with an odd NUL or space inside at times
  function automatic logic [255:0] with_short_name(logic [255:0] e, int nl, int el);
    logic [7:0] ch;
    int i;
    for (i = 0; i < 11; i++) begin
      ch = 8'($urandom_range(33, 126));
      if (i < 8) e[8*i +: 8] = (i < nl) ? ch : SPACE;
      else e[8*i +: 8] = (i - 8 < el) ? ch : SPACE;
    end
    case ($urandom_range(0, 5))
      0: e[8*$urandom_range(1, 10) +: 8] = NUL;
      1: e[8*$urandom_range(1, 10) +: 8] = SPACE;
      default: ;
    endcase
    return e;
  endfunction

  function automatic logic [7:0] pick_file_attr();
    logic [7:0] a;
    a = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 2))
      0: a = (a & ~ATTR_ARCHIVE) | ATTR_DIR;
      1: a = (a & ~ATTR_DIR) | ATTR_ARCHIVE;
      default: a = a | ATTR_DIR | ATTR_ARCHIVE;
    endcase
    return a;
  endfunction

  function automatic bit entry_matters(logic [255:0] e);
    if (byte_at(e, 0) == FIRST_END) return 1'b1;
    if (byte_at(e, 0) == FIRST_DELETED) return 1'b0;
    if (byte_at(e, ATTR_BYTE) == ATTR_LONG) return 1'b1;
    return (byte_at(e, ATTR_BYTE) & (ATTR_DIR | ATTR_ARCHIVE)) != 8'h00;
  endfunction

  task automatic offer_entry(input logic [255:0] e);
    send_entry(e);
    if (entry_matters(e)) random_count++;
  endtask

  task automatic test_end_and_skip();
    logic [255:0] e;
    e = random_bits();
    e[7:0] = FIRST_END;
    send_entry(e);
    // Deleted entries are dropped, also when they look like a long name
    e = file_entry(ATTR_ARCHIVE);
    e[7:0] = FIRST_DELETED;
    send_entry(e);
    e = long_name_entry(3, NO_NUL);
    e[7:0] = FIRST_DELETED;
    send_entry(e);
    send_entry(file_entry(ATTR_VOLUME_ID));
    send_entry(named_entry("PLAIN   BIN", ATTR_ARCHIVE));
  endtask

  task automatic test_short_names();
    logic [255:0] e;
    send_entry(with_tail(named_entry("README  TXT", ATTR_ARCHIVE), '0, '0, '1));
    send_entry(with_tail(named_entry("DOCS       ", ATTR_DIR), '1, '1, '0));
    send_entry(named_entry("ABCDEFGHIJK", ATTR_DIR | ATTR_ARCHIVE));
    send_entry(named_entry("AB D    EX ", ATTR_ARCHIVE));
    // NUL inside the name part, then NUL leading the extension
    e = named_entry("ABXDEFGHXYZ", ATTR_ARCHIVE);
    e[23:16] = NUL;
    send_entry(e);
    e = named_entry("NAME    ABC", ATTR_DIR);
    e[71:64] = NUL;
    send_entry(e);
    send_entry(named_entry("           ", ATTR_DIR));
  endtask

  task automatic test_long_names();
    logic [255:0] e;
    send_entry(long_name_entry(1, NO_NUL));
    send_entry(long_name_entry(0, 0));
    send_entry(long_name_entry(SLOT_COUNT - 1, 5));
    send_entry(with_tail(file_entry(ATTR_ARCHIVE), '1, '0, '0));
    // Overwrite one slot before the entry that uses it
    send_entry(long_name_entry(7, NO_NUL));
    send_entry(long_name_entry(7, NAME_LEN - 1));
    send_entry(file_entry(ATTR_DIR));
    // End of directory drops stored slots
    send_entry(long_name_entry(4, 2));
    e = random_bits();
    e[7:0] = FIRST_END;
    send_entry(e);
    send_entry(named_entry("AFTER   END", ATTR_ARCHIVE));
  endtask

  task automatic test_full_slot_set();
    int order [SLOT_COUNT];
    int i, j, t;
    for (i = 0; i < SLOT_COUNT; i++) order[i] = i;
    for (i = SLOT_COUNT - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    for (i = 0; i < SLOT_COUNT; i++) send_entry(long_name_entry(order[i], $urandom_range(0, 16)));
    send_entry(file_entry(pick_file_attr()));
  endtask

  task automatic test_random_traffic();
    logic [255:0] e;
    bit paused;
    int choice, runs;
    paused = 1'b0;
    while (random_count < RANDOM_ENTRIES) begin
      if (random_count >= RANDOM_ENTRIES - CALM_TAIL) quiet = 1'b1;
      // Hold the sender once until every expected result is out
      if (!paused && random_count >= RANDOM_ENTRIES / 2) begin
        wait_for_results();
        paused = 1'b1;
      end
      choice = $urandom_range(0, 9);
      if (choice <= 5) begin
        runs = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 16) : $urandom_range(1, 4);
        repeat (runs) offer_entry(long_name_entry($urandom_range(0, SLOT_COUNT - 1),
                                                  $urandom_range(0, 16)));
        offer_entry(file_entry(pick_file_attr()));
      end else if (choice == 6) begin
        offer_entry(with_short_name(file_entry(pick_file_attr()),
                                    $urandom_range(0, 8), $urandom_range(0, 3)));
      end else if (choice == 7) begin
        offer_entry(random_bits());
      end else if (choice == 8) begin
        // Broken sequence: names cut off by an end, deleted or ignored entry
        repeat ($urandom_range(1, 3))
          offer_entry(long_name_entry($urandom_range(0, SLOT_COUNT - 1), $urandom_range(0, 16)));
        e = file_entry(pick_file_attr());
        case ($urandom_range(0, 2))
          0: e[7:0] = FIRST_END;
          1: e[7:0] = FIRST_DELETED;
          default: e[8*ATTR_BYTE +: 8] = ATTR_VOLUME_ID;
        endcase
        offer_entry(e);
      end else begin
        e = random_bits();
        e[7:0] = ($urandom_range(0, 1) == 0) ? FIRST_END : FIRST_DELETED;
        offer_entry(e);
      end
    end
  endtask

  // Give up on a hung run
  initial begin
    while (cycle_count < LIMIT_CYCLES) @(posedge clk);
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
             awaited_pieces.size());
    $display("simulation failed");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_end_and_skip();
    test_short_names();
    test_long_names();
    test_full_slot_set();
    test_random_traffic();

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d entries and %0d results, %0d of them end-of-directory records",
             entries_accepted, results_seen, end_records);
    $display("longest name run was %0d pieces; %0d mismatches", most_pieces, mismatches);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
